// ===== hw/rtl/tdf_pkg.sv =====
// Shared types, constants and the microcode program for the trial division factorizer.
// Used by tdf_sequencer and trial_division_factorizer; depends on nothing else.
`timescale 1ns / 1ps

package tdf_pkg;

	// Fixed field widths of the ports and result limits.
	localparam int VALUE_W     = 32;
	localparam int PRIME_W     = 32;
	localparam int EXP_W       = 5;
	localparam int MAX_RESULTS = 9;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int PC_W        = 4;

	localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

	// Datapath operations, one per control word.
	typedef enum logic [3:0] {
		UOP_NOP      = 4'd0,
		UOP_LOAD     = 4'd1,
		UOP_DSTART   = 4'd2,
		UOP_TAKE     = 4'd3,
		UOP_PUSH_DIV = 4'd4,
		UOP_PUSH_REM = 4'd5,
		UOP_NEXT     = 4'd6,
		UOP_FLUSH    = 4'd7,
		UOP_EMPTY    = 4'd8
	} uop_t;

	// Jump conditions tested by the sequencer.
	typedef enum logic [2:0] {
		COND_NEVER      = 3'd0,
		COND_ALWAYS     = 3'd1,
		COND_NO_IN      = 3'd2,
		COND_REM_LE1    = 3'd3,
		COND_DIV_BUSY   = 3'd4,
		COND_DIV_GT_QUO = 3'd5,
		COND_REM_NZ     = 3'd6,
		COND_MULT_ZERO  = 3'd7
	} cond_t;

	// Program addresses.
	localparam logic [PC_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [PC_W-1:0] ST_CHECK  = 4'd1;
	localparam logic [PC_W-1:0] ST_DSTART = 4'd2;
	localparam logic [PC_W-1:0] ST_DWAIT  = 4'd3;
	localparam logic [PC_W-1:0] ST_TLOOP  = 4'd4;
	localparam logic [PC_W-1:0] ST_TREM   = 4'd5;
	localparam logic [PC_W-1:0] ST_TAKE   = 4'd6;
	localparam logic [PC_W-1:0] ST_TMULT  = 4'd7;
	localparam logic [PC_W-1:0] ST_PUSHD  = 4'd8;
	localparam logic [PC_W-1:0] ST_NEXT   = 4'd9;
	localparam logic [PC_W-1:0] ST_TTAIL  = 4'd10;
	localparam logic [PC_W-1:0] ST_PUSHR  = 4'd11;
	localparam logic [PC_W-1:0] ST_FLUSH  = 4'd12;
	localparam logic [PC_W-1:0] ST_EMPTY  = 4'd13;

	// One control word: operation, jump condition and jump target.
	typedef struct packed {
		uop_t            op;
		cond_t           cond;
		logic [PC_W-1:0] tgt;
	} ucw_t;

	// Status flags from the datapath to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic rem_le1;
		logic div_busy;
		logic div_gt_quo;
		logic rem_nz;
		logic mult_zero;
		logic stall;
	} stat_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		uop_t op;
		logic exec;
	} ctrl_t;

	// Microcode program. A taken condition jumps to tgt, otherwise the step counter advances.
	function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
		ucw_t w;
		case (pc)
			ST_IDLE:   w = '{UOP_LOAD,     COND_NO_IN,      ST_IDLE};
			ST_CHECK:  w = '{UOP_NOP,      COND_REM_LE1,    ST_EMPTY};
			ST_DSTART: w = '{UOP_DSTART,   COND_NEVER,      ST_IDLE};
			ST_DWAIT:  w = '{UOP_NOP,      COND_DIV_BUSY,   ST_DWAIT};
			ST_TLOOP:  w = '{UOP_NOP,      COND_DIV_GT_QUO, ST_TTAIL};
			ST_TREM:   w = '{UOP_NOP,      COND_REM_NZ,     ST_TMULT};
			ST_TAKE:   w = '{UOP_TAKE,     COND_ALWAYS,     ST_DSTART};
			ST_TMULT:  w = '{UOP_NOP,      COND_MULT_ZERO,  ST_NEXT};
			ST_PUSHD:  w = '{UOP_PUSH_DIV, COND_NEVER,      ST_IDLE};
			ST_NEXT:   w = '{UOP_NEXT,     COND_ALWAYS,     ST_DSTART};
			ST_TTAIL:  w = '{UOP_NOP,      COND_REM_LE1,    ST_FLUSH};
			ST_PUSHR:  w = '{UOP_PUSH_REM, COND_NEVER,      ST_IDLE};
			ST_FLUSH:  w = '{UOP_FLUSH,    COND_ALWAYS,     ST_IDLE};
			ST_EMPTY:  w = '{UOP_EMPTY,    COND_ALWAYS,     ST_IDLE};
			default:   w = '{UOP_NOP,      COND_ALWAYS,     ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/trial_division_factorizer.sv =====
// Trial division prime factorizer: one value in, one (prime, exponent) beat out per prime.
// Each trial divisor starts the bit-serial divider, waits while it is busy, tests the loop bound
// and the remainder, and then divides the factor out or records it and moves to the next divisor;
// values 0 and 1 skip the division and give the empty result.
// One item is worked at a time; the next is taken once the last result sits in the output register.
// Asynchronous active-low reset returns the sequencer to idle with no result pending.
`timescale 1ns / 1ps

module trial_division_factorizer #(
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tdf_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tdf_pkg::PRIME_W-1:0]  prime,
	output logic [tdf_pkg::EXP_W-1:0]    exponent,
	output logic                         empty_res,
	output logic                         last
);

	import tdf_pkg::*;

	localparam int DW = VALUE_BITS;

	stat_t stat;
	ctrl_t ctrl;

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [EXP_W-1:0] mult_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_valid_q;
	logic [DW-1:0]    pend_prime_q;
	logic [EXP_W-1:0] pend_exp_q;

	logic             out_valid_q;
	logic [PRIME_W-1:0] prime_q;
	logic [EXP_W-1:0] exponent_q;
	logic             empty_q;
	logic             last_q;

	logic             dv_start;
	logic             dv_busy;
	logic [DW-1:0]    dv_quo;
	logic [DW-1:0]    dv_rem;

	logic             is_push;
	logic             room;
	logic             out_free;
	logic             need_out;
	logic             run;
	logic [DW-1:0]    new_prime;
	logic [EXP_W-1:0] new_exp;

	tdf_divider #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (rem_q),
		.divisor  (div_q),
		.busy     (dv_busy),
		.quo      (dv_quo),
		.rem      (dv_rem)
	);

	tdf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Decode of the current operation and the output-register stall.
	always_comb begin
		is_push  = (ctrl.op == UOP_PUSH_DIV) || (ctrl.op == UOP_PUSH_REM);
		room     = (cnt_q < CNT_W'(MAX_RESULTS));
		out_free = !out_valid_q || out_ready;
		need_out = (ctrl.op == UOP_EMPTY)
			|| ((ctrl.op == UOP_FLUSH) && pend_valid_q)
			|| (is_push && pend_valid_q && room);
		run       = ctrl.exec;
		new_prime = (ctrl.op == UOP_PUSH_DIV) ? div_q : rem_q;
		new_exp   = (ctrl.op == UOP_PUSH_DIV) ? mult_q : EXP_W'(1);
	end

	// Status flags for the sequencer. The loop bound is only tested for a fresh divisor;
	// once a divisor has divided, it is divided out until it no longer does.
	always_comb begin
		stat.in_valid   = in_valid;
		stat.rem_le1    = (rem_q <= DW'(1));
		stat.div_busy   = dv_busy;
		stat.div_gt_quo = (div_q > dv_quo) && (mult_q == '0);
		stat.rem_nz     = (dv_rem != '0);
		stat.mult_zero  = (mult_q == '0);
		stat.stall      = need_out && !out_free;
	end

	assign dv_start = run && (ctrl.op == UOP_DSTART);
	assign in_ready = run && (ctrl.op == UOP_LOAD);

	// Working registers: remaining value, trial divisor, multiplicity and result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q        <= '0;
			div_q        <= DW'(2);
			mult_q       <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else if (run) begin
			case (ctrl.op)
				UOP_LOAD: begin
					if (in_valid) begin
						rem_q        <= DW'(value);
						div_q        <= DW'(2);
						mult_q       <= '0;
						cnt_q        <= '0;
						pend_valid_q <= 1'b0;
					end
				end
				UOP_TAKE: begin
					rem_q  <= dv_quo;
					mult_q <= (mult_q == EXP_MAX) ? mult_q : mult_q + 1'b1;
				end
				UOP_NEXT: begin
					div_q  <= div_q + 1'b1;
					mult_q <= '0;
				end
				UOP_PUSH_DIV, UOP_PUSH_REM: begin
					if (room) begin
						pend_valid_q <= 1'b1;
						cnt_q        <= cnt_q + 1'b1;
					end
				end
				UOP_FLUSH: begin
					pend_valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Pending result, held back until it is known whether it is the last one.
	always_ff @(posedge clk) begin
		if (run && is_push && room) begin
			pend_prime_q <= new_prime;
			pend_exp_q   <= new_exp;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run && need_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (run && need_out) begin
			if (ctrl.op == UOP_EMPTY) begin
				prime_q    <= '0;
				exponent_q <= '0;
				empty_q    <= 1'b1;
				last_q     <= 1'b1;
			end else begin
				prime_q    <= PRIME_W'(pend_prime_q);
				exponent_q <= pend_exp_q;
				empty_q    <= 1'b0;
				last_q     <= (ctrl.op == UOP_FLUSH);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign prime     = prime_q;
	assign exponent  = exponent_q;
	assign empty_res = empty_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	// A finished division leaves a remainder below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(dv_busy) |-> (dv_rem < div_q))
		else $error("divider remainder not below divisor");

	// The result count never passes the limit.
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("result count above limit");

	// The trial divisor never falls below two.
	a_div_min: assert property (@(posedge clk) disable iff (!arst_n)
		div_q >= DW'(2))
		else $error("trial divisor below two");

	// A divisor is only recorded with a nonzero multiplicity.
	a_push_mult: assert property (@(posedge clk) disable iff (!arst_n)
		(run && (ctrl.op == UOP_PUSH_DIV)) |-> (mult_q != '0))
		else $error("divisor recorded with zero multiplicity");

	// The empty result never leaves a factor pending.
	a_empty_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(run && (ctrl.op == UOP_EMPTY)) |-> !pend_valid_q)
		else $error("empty result with a pending factor");

	// Flushing leaves nothing pending.
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(run && (ctrl.op == UOP_FLUSH)) |=> !pend_valid_q)
		else $error("pending factor survived flush");
`endif

endmodule

// ===== hw/rtl/tdf_divider.sv =====
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Standalone; used by trial_division_factorizer.
`timescale 1ns / 1ps

module tdf_divider #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quo,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;

	// Trial subtraction of the divisor from the partial remainder with the next bit shifted in.
	assign trial = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};

	// Iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Quotient and remainder shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/tdf_sequencer.sv =====
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on tdf_pkg; used by trial_division_factorizer.
`timescale 1ns / 1ps

module tdf_sequencer (
	input  logic           clk,
	input  logic           arst_n,
	input  tdf_pkg::stat_t stat,
	output tdf_pkg::ctrl_t ctrl
);

	import tdf_pkg::*;

	logic [PC_W-1:0] pc_q;
	ucw_t            cw;
	logic            taken;

	// Fetch the control word of the current step.
	always_comb begin
		cw = ucode_rom(pc_q);
	end

	// Evaluate the jump condition.
	always_comb begin
		case (cw.cond)
			COND_NEVER:      taken = 1'b0;
			COND_ALWAYS:     taken = 1'b1;
			COND_NO_IN:      taken = !stat.in_valid;
			COND_REM_LE1:    taken = stat.rem_le1;
			COND_DIV_BUSY:   taken = stat.div_busy;
			COND_DIV_GT_QUO: taken = stat.div_gt_quo;
			COND_REM_NZ:     taken = stat.rem_nz;
			COND_MULT_ZERO:  taken = stat.mult_zero;
			default:         taken = 1'b1;
		endcase
	end

	assign ctrl.op   = cw.op;
	assign ctrl.exec = !stat.stall;

	// Step counter; a stalled step repeats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (!stat.stall) begin
			pc_q <= taken ? cw.tgt : pc_q + 1'b1;
		end
	end

endmodule
